// ===== rtl/sjfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjfq_pkg
// Shared constants and types for the shortest-job-first queue.
// ----------------------------------------------------------------------------
package sjfq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int KEY_W       = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 7;
  localparam int STAT_W      = 2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } stat_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins_en;
    logic pop_en;
    key_t key;
  } cell_ctl_t;

endpackage : sjfq_pkg
`default_nettype wire

// ===== rtl/shortest_job_first_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_job_first_queue
// Bounded queue of service-time keys kept in ascending order; insert or pop.
// ----------------------------------------------------------------------------
// The keys live in a row of QUEUE_DEPTH cells, smallest at the head. Every
// cell compares its key with the incoming one in parallel, and one item is
// taken per cycle while in_stall is low; each item yields one result through
// a single output register, and in_stall rises only while that register holds
// a result the consumer has not taken. Equal keys leave in arrival order.
// Insert into a full queue is dropped with status overflow, pop on an empty
// queue reports underflow.
// ----------------------------------------------------------------------------
module shortest_job_first_queue
  import sjfq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              mode,
  input  wire logic [KEY_W-1:0]  key,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [KEY_W-1:0]       popped_key,
  output logic                   popped_valid,
  output logic [OCC_W-1:0]       occupancy,
  output logic                   is_empty,
  output logic [STAT_W-1:0]      status
);

  cnt_t      count;
  cnt_t      count_next;
  cell_ctl_t ctl;
  logic      accept;
  logic      full;
  logic      empty;
  stat_t     stat_next;
  logic [QUEUE_DEPTH-1:0] gt;
  key_t      cell_key [QUEUE_DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == cnt_t'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  assign ctl.ins_en = accept && !mode && !full;
  assign ctl.pop_en = accept && mode && !empty;
  assign ctl.key    = key;

  always_comb begin
    count_next = count;
    stat_next  = STAT_OK;
    if (!mode) begin
      if (full) begin
        stat_next = STAT_OVERFLOW;
      end else begin
        count_next = count + cnt_t'(1);
      end
    end else begin
      if (empty) begin
        stat_next = STAT_UNDERFLOW;
      end else begin
        count_next = count - cnt_t'(1);
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic lgt;
    key_t lkey;
    key_t rkey;
    if (i == 0) begin : g_head
      assign lgt  = 1'b0;
      assign lkey = '0;
    end else begin : g_body
      assign lgt  = gt[i-1];
      assign lkey = cell_key[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rkey = '0;
    end else begin : g_mid
      assign rkey = cell_key[i+1];
    end
    sjfq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (cnt_t'(i) < count),
      .at_tail   (cnt_t'(i) == count),
      .left_gt   (lgt),
      .left_key  (lkey),
      .right_key (rkey),
      .gt        (gt[i]),
      .key_q     (cell_key[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_key   <= ctl.pop_en ? cell_key[0] : '0;
      popped_valid <= ctl.pop_en;
      occupancy    <= OCC_W'(count_next);
      is_empty     <= (count_next == '0);
      status       <= stat_next;
    end
  end

  // assertions
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(QUEUE_DEPTH))
    else $error("count above depth");

  a_ins_grows : assert property (@(posedge clk) disable iff (rst)
    ctl.ins_en |=> count == $past(count) + cnt_t'(1))
    else $error("insert did not grow count");

  a_pop_shrinks : assert property (@(posedge clk) disable iff (rst)
    ctl.pop_en |=> count == $past(count) - cnt_t'(1))
    else $error("pop did not shrink count");

  a_pop_ok : assert property (@(posedge clk) disable iff (rst)
    out_valid && popped_valid |-> status == STAT_OK)
    else $error("popped item flagged with error status");

endmodule : shortest_job_first_queue
`default_nettype wire

// ===== rtl/sjfq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjfq_cell
// One slot of the sorted chain: holds a key, compares it with the incoming
// key and shifts toward the tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
module sjfq_cell
  import sjfq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occupied,
  input  wire logic      at_tail,
  input  wire logic      left_gt,
  input  wire key_t      left_key,
  input  wire key_t      right_key,
  output logic           gt,
  output key_t           key_q
);

  assign gt = occupied && (key_q > ctl.key);

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (left_gt) begin
        key_q <= left_key;
      end else if (gt || at_tail) begin
        key_q <= ctl.key;
      end
    end else if (ctl.pop_en) begin
      key_q <= right_key;
    end
  end

endmodule : sjfq_cell
`default_nettype wire
